// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property p must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, p, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (p)) else $error(msg);

// When a holds, b must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ----- hw/rtl/scrc_pkg.sv -----
package scrc_pkg;

    localparam int CordicSteps = 32;
    localparam int WorkWidth = 40;
    localparam int AngleWidth = 34;
    localparam int CoordFracBits = 14;

    localparam logic [1:0] RegionEven = 2'd0;
    localparam logic [1:0] RegionOdd = 2'd1;
    localparam logic [1:0] RegionLine = 2'd2;

    localparam logic [1:0] CfgAzimuthCells = 2'd0;
    localparam logic [1:0] CfgPolarCells = 2'd1;
    localparam logic [1:0] CfgPolarBand = 2'd2;
    localparam logic [1:0] CfgAzimuthBand = 2'd3;

    typedef struct packed {
        logic signed [WorkWidth-1:0] ax;
        logic signed [WorkWidth-1:0] ay;
        logic signed [AngleWidth-1:0] aang;
        logic signed [WorkWidth-1:0] px;
        logic signed [WorkWidth-1:0] py;
        logic signed [AngleWidth-1:0] pang;
        logic az_zero;
        logic pol_pole;
        logic pol_north;
    } cordic_data_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'h20000000;
            1: t = 32'h12E4051E;
            2: t = 32'h09FB385B;
            3: t = 32'h051111D4;
            4: t = 32'h028B0D43;
            5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;
            7: t = 32'h00517C55;
            8: t = 32'h0028BE53;
            9: t = 32'h00145F2F;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2FA;
            15: t = 32'h0000517D;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A30;
            19: t = 32'h00000518;
            20: t = 32'h0000028C;
            21: t = 32'h00000146;
            22: t = 32'h000000A3;
            23: t = 32'h00000051;
            24: t = 32'h00000029;
            25: t = 32'h00000014;
            26: t = 32'h0000000A;
            27: t = 32'h00000005;
            28: t = 32'h00000003;
            29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

// ----- hw/rtl/scrc_isqrt_cell.sv -----
module scrc_isqrt_cell #(
    parameter int Width = 32,
    parameter int Step = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [Width-1:0] in_rem,
    input  logic [Width-1:0] in_root,
    input  logic [47:0]      in_side,
    output logic             out_valid,
    output logic [Width-1:0] out_rem,
    output logic [Width-1:0] out_root,
    output logic [47:0]      out_side
);

    localparam logic [Width-1:0] Bit = Width'(1) << (Width - 2 - 2 * Step);

    logic [Width-1:0] rem_next;
    logic [Width-1:0] root_next;
    logic             valid_reg;
    logic [Width-1:0] rem_reg;
    logic [Width-1:0] root_reg;
    logic [47:0]      side_reg;

    always_comb
    begin
        if (in_rem >= in_root + Bit)
        begin
            rem_next = in_rem - (in_root + Bit);
            root_next = (in_root >> 1) + Bit;
        end
        else
        begin
            rem_next = in_rem;
            root_next = in_root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem = rem_reg;
    assign out_root = root_reg;
    assign out_side = side_reg;

endmodule

// ----- hw/rtl/scrc_cordic_cell.sv -----
module scrc_cordic_cell #(
    parameter int Step = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  scrc_pkg::cordic_data_t    in_data,
    output logic                      out_valid,
    output scrc_pkg::cordic_data_t    out_data
);

    localparam logic signed [scrc_pkg::AngleWidth-1:0] Turn =
        $signed({2'b00, scrc_pkg::atan_turn(Step)});

    scrc_pkg::cordic_data_t data_next;
    scrc_pkg::cordic_data_t data_reg;
    logic                   valid_reg;

    always_comb
    begin
        data_next = in_data;
        if (!in_data.ay[scrc_pkg::WorkWidth-1])
        begin
            data_next.ax = in_data.ax + (in_data.ay >>> Step);
            data_next.ay = in_data.ay - (in_data.ax >>> Step);
            data_next.aang = in_data.aang + Turn;
        end
        else
        begin
            data_next.ax = in_data.ax - (in_data.ay >>> Step);
            data_next.ay = in_data.ay + (in_data.ax >>> Step);
            data_next.aang = in_data.aang - Turn;
        end
        if (!in_data.py[scrc_pkg::WorkWidth-1])
        begin
            data_next.px = in_data.px + (in_data.py >>> Step);
            data_next.py = in_data.py - (in_data.px >>> Step);
            data_next.pang = in_data.pang + Turn;
        end
        else
        begin
            data_next.px = in_data.px - (in_data.py >>> Step);
            data_next.py = in_data.py + (in_data.px >>> Step);
            data_next.pang = in_data.pang - Turn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

// ----- hw/rtl/sphere_checker_region_classifier.sv -----
// Pipeline: from the register that accepts start to the done register there are
// 1 input, 16 square-root cells, 1 setup, 32 CORDIC cells, 1 angle, 1 scale,
// 1 classify and output register.
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// Reset clears all valid flags and loads the register reset values.
// The receiver cannot stall: done is a one-cycle strobe.
module sphere_checker_region_classifier #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [15:0] hit_x,
    input  logic signed [15:0] hit_y,
    input  logic signed [15:0] hit_z,
    output logic              done,
    output logic [1:0]        region,
    output logic [7:0]        azimuth_index,
    output logic [7:0]        polar_index,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_data
);

    localparam int Cfb = scrc_pkg::CoordFracBits;
    localparam int SqWidth = 2 * Cfb + 4;
    localparam int SqSteps = SqWidth / 2;
    localparam int Aw = scrc_pkg::AngleWidth;
    localparam int Ww = scrc_pkg::WorkWidth;
    localparam int Fb = ANGLE_FRAC_BITS;
    localparam logic signed [17:0] One = 18'sd1 <<< Cfb;
    localparam logic [SqWidth-1:0] OneSq = SqWidth'(1) << (2 * Cfb);

    logic [7:0] az_cells_reg;
    logic [7:0] pol_cells_reg;
    logic [8:0] pol_band_reg;
    logic [8:0] az_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_cells_reg <= 8'd20;
            pol_cells_reg <= 8'd10;
            pol_band_reg <= 9'd0;
            az_band_reg <= 9'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                scrc_pkg::CfgAzimuthCells: az_cells_reg <= cfg_data[7:0];
                scrc_pkg::CfgPolarCells: pol_cells_reg <= cfg_data[7:0];
                scrc_pkg::CfgPolarBand: pol_band_reg <= cfg_data;
                scrc_pkg::CfgAzimuthBand: az_band_reg <= cfg_data;
                default: az_cells_reg <= az_cells_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy = 1'b0;

    // Input stage: clamp y and form 1 - y*y.
    logic              in_valid_reg;
    logic [SqWidth-1:0] sq_in_reg;
    logic [47:0]        side_in_reg;
    logic signed [17:0] yc;
    logic signed [SqWidth-1:0] yw;

    always_comb
    begin
        yc = 18'(hit_y);
        if (yc > One)
        begin
            yc = One;
        end
        if (yc < -One)
        begin
            yc = -One;
        end
        yw = SqWidth'(yc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_in_reg <= OneSq - SqWidth'(yw * yw);
        side_in_reg <= {hit_x, yc[15:0], hit_z};
    end

    logic               sq_valid [SqSteps+1];
    logic [SqWidth-1:0] sq_rem [SqSteps+1];
    logic [SqWidth-1:0] sq_root [SqSteps+1];
    logic [47:0]        sq_side [SqSteps+1];

    assign sq_valid[0] = in_valid_reg;
    assign sq_rem[0] = sq_in_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = side_in_reg;

    for (genvar g = 0; g < SqSteps; g++)
    begin : g_sq
        scrc_isqrt_cell #(.Width(SqWidth), .Step(g)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(sq_valid[g]), .in_rem(sq_rem[g]), .in_root(sq_root[g]),
            .in_side(sq_side[g]),
            .out_valid(sq_valid[g+1]), .out_rem(sq_rem[g+1]), .out_root(sq_root[g+1]),
            .out_side(sq_side[g+1])
        );
    end

    // Setup stage: scale vectors and fold the left half-plane.
    logic                   cs_valid_reg;
    scrc_pkg::cordic_data_t cs_reg;
    scrc_pkg::cordic_data_t cs_next;
    logic signed [15:0]     sx;
    logic signed [15:0]     sy;
    logic signed [15:0]     sz;
    logic [SqWidth-1:0]     s_root;

    always_comb
    begin
        sx = sq_side[SqSteps][47:32];
        sy = sq_side[SqSteps][31:16];
        sz = sq_side[SqSteps][15:0];
        s_root = sq_root[SqSteps];
        cs_next.az_zero = (sx == 16'sd0) && (sz == 16'sd0);
        cs_next.pol_pole = (s_root == '0);
        cs_next.pol_north = !sy[15] && (sy != 16'sd0);
        cs_next.ax = Ww'(sz) <<< 20;
        cs_next.ay = Ww'(sx) <<< 20;
        cs_next.aang = '0;
        if (sz[15])
        begin
            cs_next.ax = -cs_next.ax;
            cs_next.ay = -cs_next.ay;
            cs_next.aang = Aw'(64'h80000000);
        end
        cs_next.px = Ww'(sy) <<< 20;
        cs_next.py = Ww'($signed({1'b0, s_root})) <<< 20;
        cs_next.pang = '0;
        if (sy[15])
        begin
            cs_next.px = -cs_next.px;
            cs_next.py = -cs_next.py;
            cs_next.pang = Aw'(64'h80000000);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_valid_reg <= 1'b0;
        end
        else
        begin
            cs_valid_reg <= sq_valid[SqSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        cs_reg <= cs_next;
    end

    logic                   co_valid [scrc_pkg::CordicSteps+1];
    scrc_pkg::cordic_data_t co_data [scrc_pkg::CordicSteps+1];

    assign co_valid[0] = cs_valid_reg;
    assign co_data[0] = cs_reg;

    for (genvar g = 0; g < scrc_pkg::CordicSteps; g++)
    begin : g_co
        scrc_cordic_cell #(.Step(g)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(co_valid[g]), .in_data(co_data[g]),
            .out_valid(co_valid[g+1]), .out_data(co_data[g+1])
        );
    end

    // Angle stage: wrap azimuth, clamp polar angle.
    scrc_pkg::cordic_data_t cf;
    logic [31:0]            phi_next;
    logic signed [Aw-1:0]   th;
    logic [32:0]            th_next;
    logic                   an_valid_reg;
    logic [Fb-1:0]          phi_reg;
    logic [Fb:0]            th_reg;

    always_comb
    begin
        cf = co_data[scrc_pkg::CordicSteps];
        phi_next = cf.az_zero ? 32'd0 : cf.aang[31:0];
        th = cf.pang;
        if (th < 0)
        begin
            th = '0;
        end
        if (th > Aw'(64'h80000000))
        begin
            th = Aw'(64'h80000000);
        end
        if (cf.pol_pole)
        begin
            th = cf.pol_north ? '0 : Aw'(64'h80000000);
        end
        th_next = {th[31:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            an_valid_reg <= 1'b0;
        end
        else
        begin
            an_valid_reg <= co_valid[scrc_pkg::CordicSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        phi_reg <= phi_next[31 -: Fb];
        th_reg <= th_next[32 -: (Fb + 1)];
    end

    // Scale stage: multiply by the cell counts.
    logic              sc_valid_reg;
    logic [Fb+7:0]     sphi_reg;
    logic [Fb+8:0]     sth_reg;
    logic [7:0]        ac;
    logic [7:0]        pc;

    assign ac = (az_cells_reg == 8'd0) ? 8'd1 : az_cells_reg;
    assign pc = (pol_cells_reg == 8'd0) ? 8'd1 : pol_cells_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
        end
        else
        begin
            sc_valid_reg <= an_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sphi_reg <= (Fb + 8)'(phi_reg) * (Fb + 8)'(ac);
        sth_reg <= (Fb + 9)'(th_reg) * (Fb + 9)'(pc);
    end

    // Classify stage.
    logic [Fb-1:0]  fphi;
    logic [Fb-1:0]  fth;
    logic [8:0]     iphi;
    logic [8:0]     ith;
    logic           line_next;
    logic [1:0]     region_next;
    logic [Fb+9:0]  one_s;
    logic [Fb+9:0]  lim_a;
    logic [Fb+9:0]  lim_p;
    logic [Fb+9:0]  fa;
    logic [Fb+9:0]  fp;

    always_comb
    begin
        fphi = sphi_reg[Fb-1:0];
        fth = sth_reg[Fb-1:0];
        iphi = {1'b0, sphi_reg[Fb+7:Fb]};
        ith = sth_reg[Fb+8:Fb];
        one_s = (Fb + 10)'(1) << Fb;
        lim_a = (Fb + 10)'(az_band_reg) << Fb;
        lim_p = (Fb + 10)'(pol_band_reg) << Fb;
        fa = (Fb + 10)'(fphi);
        fp = (Fb + 10)'(fth);
        line_next = ((fa << 9) < lim_a) || (((one_s - fa) << 9) < lim_a)
            || ((fp << 9) < lim_p) || (((one_s - fp) << 9) < lim_p);
        if (line_next)
        begin
            region_next = scrc_pkg::RegionLine;
        end
        else if (iphi[0] ^ ith[0])
        begin
            region_next = scrc_pkg::RegionOdd;
        end
        else
        begin
            region_next = scrc_pkg::RegionEven;
        end
    end

    logic       done_reg;
    logic [1:0] region_reg;
    logic [7:0] az_idx_reg;
    logic [7:0] pol_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        region_reg <= region_next;
        az_idx_reg <= iphi[7:0];
        pol_idx_reg <= ith[7:0];
    end

    assign done = done_reg;
    assign region = region_reg;
    assign azimuth_index = az_idx_reg;
    assign polar_index = pol_idx_reg;

endmodule

// ----- hw/rtl/scrc_checker.sv -----
`include "assert_macros.svh"

module scrc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] region,
    input logic       cfg_ready
);

    `ASSERT_CLK(a_region_code, clk, rst_n, !done || region == scrc_pkg::RegionEven || region == scrc_pkg::RegionOdd || region == scrc_pkg::RegionLine, "bad region code")
    `ASSERT_CLK(a_never_busy, clk, rst_n, !busy, "pipeline reported busy")
    `ASSERT_CLK(a_cfg_ready, clk, rst_n, cfg_ready, "config port stalled")
    `ASSERT_NEXT(a_start_to_done, clk, rst_n, start && !busy, ##52 done, "missing done")
    `ASSERT_CLK(a_done_from_start, clk, rst_n, !done || $past(start && !busy, 53), "unexpected done")

endmodule

bind sphere_checker_region_classifier scrc_checker u_scrc_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .region(region), .cfg_ready(cfg_ready)
);
